FILE: hdl/sid_pkg.sv
// Shared constants and control types for the signed integer divider.
package sid_pkg;

  // Default operand width
  localparam int unsigned SID_DATA_WIDTH = 32;

  // Sequencer to cell row: start a request, run one shift-subtract step
  typedef struct packed {
    logic load;
    logic step;
  } sid_ctl_t;

  // Row to each cell: the sequencer controls plus this step's subtract decision
  typedef struct packed {
    logic load;
    logic step;
    logic sub;
  } sid_cell_ctl_t;

endpackage

FILE: hdl/signed_integer_divider.sv
// Top level of the signed integer divider: sequencer, sign handling, output register.
// Signed divider, quotient truncated toward zero, no remainder. For each request the operands
// are taken and their magnitudes loaded into a row of DATA_WIDTH bit-slice cells, then
// DATA_WIDTH restoring shift-subtract steps run through that row (one quotient bit per cycle),
// then a sign fix-up writes the result into the output register once that register is free.
// The row holds one request at a time, so a new request is taken once the previous one has
// left the row; a finished result may still wait in the output register meanwhile. Flags in
// m_tuser_o: overflowed (most negative over minus one, quotient saturated to the largest
// positive value) and divide_by_zero (quotient is then the largest positive value).
module signed_integer_divider import sid_pkg::*; #(
  parameter int unsigned DATA_WIDTH = SID_DATA_WIDTH,
  localparam int unsigned IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [IN_W-1:0]  s_tdata_i,   // dividend, divisor, zero fill
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o,   // quotient, zero fill
  output logic [1:0]       m_tuser_o    // overflowed, divide_by_zero
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } sid_state_e;

  sid_state_e            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  dbz_q, dbz_d;
  logic                  out_vld_q, out_vld_d;
  logic [DATA_WIDTH-1:0] out_q, out_d;
  logic                  ovf_out_q, ovf_out_d;
  logic                  dbz_out_q, dbz_out_d;

  logic [DATA_WIDTH-1:0] dvd;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH-1:0] dvd_mag;
  logic [DATA_WIDTH-1:0] dvs_mag;
  logic [DATA_WIDTH-1:0] quo_mag;
  logic [DATA_WIDTH-1:0] quo_res;
  logic                  ovf;
  logic                  accept;
  logic                  out_load;
  sid_ctl_t              ctl;

  // Operand magnitudes
  assign dvd     = s_tdata_i[DATA_WIDTH-1:0];
  assign dvs     = s_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH];
  assign dvd_mag = dvd[DATA_WIDTH-1] ? (~dvd + DATA_WIDTH'(1)) : dvd;
  assign dvs_mag = dvs[DATA_WIDTH-1] ? (~dvs + DATA_WIDTH'(1)) : dvs;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  assign ctl.load = accept;
  assign ctl.step = (state_q == S_RUN);

  sid_row #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_row (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .num_i (dvd_mag),
    .den_i (dvs_mag),
    .quo_o (quo_mag)
  );

  // Sign fix-up and saturation
  assign ovf = !neg_q && quo_mag[DATA_WIDTH-1];
  always_comb begin
    if (dbz_q || ovf) begin
      quo_res = MAX_POS;
    end else if (neg_q) begin
      quo_res = ~quo_mag + DATA_WIDTH'(1);
    end else begin
      quo_res = quo_mag;
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_vld_q || m_tready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dbz_d   = dbz_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          cnt_d   = CNT_W'(DATA_WIDTH - 1);
          neg_d   = dvd[DATA_WIDTH-1] ^ dvs[DATA_WIDTH-1];
          dbz_d   = (dvs == '0);
        end
      end
      S_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    ovf_out_d = ovf_out_q;
    dbz_out_d = dbz_out_q;
    if (out_load) begin
      out_vld_d = 1'b1;
      out_d     = quo_res;
      ovf_out_d = ovf && !dbz_q;
      dbz_out_d = dbz_q;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      neg_q     <= 1'b0;
      dbz_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      neg_q     <= neg_d;
      dbz_q     <= dbz_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    ovf_out_q <= ovf_out_d;
    dbz_out_q <= dbz_out_d;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = OUT_W'(out_q);
  assign m_tuser_o  = {dbz_out_q, ovf_out_q};

  // Checks
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN) && (cnt_q == CNT_W'(DATA_WIDTH - 1)))
    else $error("accepted request did not start the shift-subtract run");

  a_cnt_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (cnt_q != '0) |=> (state_q == S_RUN) && (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("step counter skipped during run");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (cnt_q == '0) |=> (state_q == S_DONE))
    else $error("run did not end after the last quotient bit");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !(m_tuser_o[0] && m_tuser_o[1]))
    else $error("overflow and divide-by-zero flagged together");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o[0] || m_tuser_o[1]) |-> (out_q == MAX_POS))
    else $error("flagged result is not the largest positive value");

endmodule

FILE: hdl/sid_cell.sv
// One bit slice of the divider: remainder, quotient/dividend and divisor bits.
module sid_cell import sid_pkg::*; (
  input  logic          clk_i,
  input  sid_cell_ctl_t ctl_i,
  input  logic          ld_num_i,    // dividend magnitude bit at load
  input  logic          ld_den_i,    // divisor magnitude bit at load
  input  logic          r_shift_i,   // remainder bit from the lower neighbor
  input  logic          q_shift_i,   // quotient bit from the lower neighbor
  input  logic          borrow_i,    // borrow from the lower neighbor
  output logic          r_o,
  output logic          q_o,
  output logic          borrow_o
);

  logic r_q, r_d;
  logic q_q, q_d;
  logic d_q, d_d;
  logic diff;

  // Full subtractor on the shifted remainder bit
  assign diff     = r_shift_i ^ d_q ^ borrow_i;
  assign borrow_o = (~r_shift_i & d_q) | (~(r_shift_i ^ d_q) & borrow_i);

  // Next state: load a new request, or shift and conditionally subtract
  always_comb begin
    r_d = r_q;
    q_d = q_q;
    d_d = d_q;
    if (ctl_i.load) begin
      r_d = 1'b0;
      q_d = ld_num_i;
      d_d = ld_den_i;
    end else if (ctl_i.step) begin
      r_d = ctl_i.sub ? diff : r_shift_i;
      q_d = q_shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    d_q <= d_d;
  end

  assign r_o = r_q;
  assign q_o = q_q;

endmodule

FILE: hdl/sid_row.sv
// Row of divider bit slices linked by shift and borrow chains.
module sid_row import sid_pkg::*; #(
  parameter int unsigned DATA_WIDTH = SID_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  sid_ctl_t              ctl_i,
  input  logic [DATA_WIDTH-1:0] num_i,   // dividend magnitude
  input  logic [DATA_WIDTH-1:0] den_i,   // divisor magnitude
  output logic [DATA_WIDTH-1:0] quo_o    // quotient magnitude after the last step
);

  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] q;
  logic [DATA_WIDTH-1:0] borrow;
  logic [DATA_WIDTH-1:0] r_in;
  logic [DATA_WIDTH-1:0] q_in;
  logic [DATA_WIDTH-1:0] b_in;
  sid_cell_ctl_t         cell_ctl;

  // Shifted remainder >= divisor when no borrow leaves the top slice
  assign cell_ctl.load = ctl_i.load;
  assign cell_ctl.step = ctl_i.step;
  assign cell_ctl.sub  = ~borrow[DATA_WIDTH-1];

  // Neighbor links: the dividend MSB enters the remainder, the decision enters the quotient
  assign r_in = {r[DATA_WIDTH-2:0], q[DATA_WIDTH-1]};
  assign q_in = {q[DATA_WIDTH-2:0], cell_ctl.sub};
  assign b_in = {borrow[DATA_WIDTH-2:0], 1'b0};

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sid_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (cell_ctl),
      .ld_num_i  (num_i[i]),
      .ld_den_i  (den_i[i]),
      .r_shift_i (r_in[i]),
      .q_shift_i (q_in[i]),
      .borrow_i  (b_in[i]),
      .r_o       (r[i]),
      .q_o       (q[i]),
      .borrow_o  (borrow[i])
    );
  end

  assign quo_o = q;

endmodule

FILE: bench/signed_integer_divider_test.sv
// Self-checking testbench for the signed integer divider: directed corners, then random requests.
`timescale 1ns / 100ps

module signed_integer_divider_test;
  import sid_pkg::*;

  localparam int unsigned W     = SID_DATA_WIDTH;
  localparam int unsigned IN_W  = ((2 * W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((W + 7) / 8) * 8;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 2 * W + 8;

  // One expected result of the divider
  typedef struct packed {
    logic [W-1:0] quotient;
    logic         overflowed;
    logic         divide_by_zero;
  } quot_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  logic [IN_W-1:0]  s_tdata_i = '0;   // dividend, divisor, zero fill
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  logic [OUT_W-1:0] m_tdata_o;        // quotient, zero fill
  logic [1:0]       m_tuser_o;        // overflowed, divide_by_zero

  quot_result_t pending_quotients[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  signed_integer_divider dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Truncating signed division by restoring shift-subtract on magnitudes
  function automatic quot_result_t predict_quotient(input logic [W-1:0] dividend,
                                                    input logic [W-1:0] divisor);
    logic         num_neg;
    logic         den_neg;
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] quo;
    logic [W:0]   rem;
    quot_result_t res;
    res = '0;
    num_neg = dividend[W-1];
    den_neg = divisor[W-1];
    if (divisor == '0) begin
      res.quotient = MAX_POS;
      res.divide_by_zero = 1'b1;
    end else begin
      num_mag = num_neg ? -dividend : dividend;
      den_mag = den_neg ? -divisor : divisor;
      rem = '0;
      quo = '0;
      for (int i = W - 1; i >= 0; i--) begin
        rem = {rem[W-1:0], num_mag[i]};
        if (rem >= {1'b0, den_mag}) begin
          rem = rem - {1'b0, den_mag};
          quo[i] = 1'b1;
        end
      end
      if (num_neg != den_neg) begin
        res.quotient = -quo;
      end else if (quo > MAX_POS) begin
        // most negative over minus one
        res.quotient = MAX_POS;
        res.overflowed = 1'b1;
      end else begin
        res.quotient = quo;
      end
    end
    return res;
  endfunction

  // Receiver stalls
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each result against the oldest pending one
  always @(posedge clk_i) begin
    quot_result_t exp_res;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_quotients.size() == 0) begin
        $error("unexpected result: quotient %h, tuser %b", m_tdata_o, m_tuser_o);
        error_count = error_count + 1;
      end else begin
        exp_res = pending_quotients.pop_front();
        if (m_tdata_o[W-1:0] !== exp_res.quotient) begin
          $error("quotient: expected %h, actual %h", exp_res.quotient, m_tdata_o[W-1:0]);
          error_count = error_count + 1;
        end
        if (m_tuser_o[0] !== exp_res.overflowed) begin
          $error("overflowed: expected %b, actual %b", exp_res.overflowed, m_tuser_o[0]);
          error_count = error_count + 1;
        end
        if (m_tuser_o[1] !== exp_res.divide_by_zero) begin
          $error("divide_by_zero: expected %b, actual %b",
                 exp_res.divide_by_zero, m_tuser_o[1]);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Send one request; called just after a rising edge, leaves tvalid high
  task automatic send_request(input logic [W-1:0] dividend, input logic [W-1:0] divisor);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= IN_W'({divisor, dividend});
    do @(posedge clk_i); while (!s_tready_o);
    pending_quotients.push_back(predict_quotient(dividend, divisor));
  endtask

  // Hold off the sender until every pending result is out
  task automatic wait_for_drain();
    s_tvalid_i <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk_i);
  endtask

  // Operand biased toward corners, small values and short magnitudes
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] val;
    case ($urandom_range(0, 5))
      0, 1: val = $urandom;
      2: val = $urandom_range(0, 15);
      3: val = $urandom >> $urandom_range(0, W - 1);
      4: begin
        case ($urandom_range(0, 4))
          0: val = '0;
          1: val = 1;
          2: val = MINUS_ONE;
          3: val = MAX_POS;
          default: val = MIN_NEG;
        endcase
      end
      default: val = $urandom >> $urandom_range(W / 2, W - 1);
    endcase
    if ($urandom_range(0, 1) != 0) val = -val;
    return val;
  endfunction

  // All sign combinations, truncation toward zero, magnitude extremes
  task automatic test_sign_combinations();
    send_request(0, 1);
    send_request(1, 1);
    send_request(7, 2);
    send_request(-7, 2);
    send_request(7, -2);
    send_request(-7, -2);
    send_request(1, 2);
    send_request(-1, 2);
    send_request(MAX_POS, 1);
    send_request(MAX_POS, MINUS_ONE);
    send_request(MAX_POS, MAX_POS);
    send_request(MAX_POS, MIN_NEG);
    send_request(MIN_NEG, 1);
    send_request(MIN_NEG, MIN_NEG);
    send_request(MIN_NEG, MAX_POS);
    send_request(MIN_NEG, 2);
    send_request(1, MAX_POS);
    send_request(MINUS_ONE, MIN_NEG);
  endtask

  // Saturating overflow and zero divisor
  task automatic test_special_cases();
    send_request(MIN_NEG, MINUS_ONE);
    send_request(0, 0);
    send_request(MAX_POS, 0);
    send_request(MIN_NEG, 0);
    send_request(MINUS_ONE, 0);
    send_request(MIN_NEG, MINUS_ONE);
  endtask

  // Random operands with occasional corner pairs and drains
  task automatic test_random_operands(input int unsigned num_requests);
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    for (int unsigned n = 0; n < num_requests; n++) begin
      dividend = random_operand();
      divisor  = random_operand();
      case ($urandom_range(0, 49))
        0: divisor = '0;
        1: begin
          dividend = MIN_NEG;
          divisor  = MINUS_ONE;
        end
        default: ;
      endcase
      send_request(dividend, divisor);
      if ($urandom_range(0, 99) == 0) wait_for_drain();
    end
  endtask

  // Sender stops until the output side is empty, then resumes
  task automatic test_drain_pauses();
    for (int unsigned n = 0; n < 4; n++) begin
      test_random_operands($urandom_range(1, 6));
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 49;
    test_sign_combinations();
    test_special_cases();
    test_random_operands(400);
    test_drain_pauses();

    send_idle_pct = 49;
    recv_idle_pct = 34;
    test_random_operands(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_operands(400);
    test_drain_pauses();

    // Let everything pending come out, then a little more
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sid_pkg.sv
hdl/sid_cell.sv
hdl/sid_row.sv
hdl/signed_integer_divider.sv
bench/signed_integer_divider_test.sv
